@@ rtl/pts_pkg.sv @@
// Shared types and constants for the periodic task scheduler.
package pts_pkg;

  localparam int unsigned SLOT_W     = 6;   // slot index field, covers up to 64 slots
  localparam int unsigned OUT_SLOT_W = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PRIO_W     = 8;

  localparam logic signed [TIME_W-1:0] WRAP_LIMIT_NEG = -32'sd1073741824;
  localparam logic [TIME_W-1:0]        WRAP_STEP      = 32'd536870912;

  typedef enum logic [1:0] {
    ACT_SELECT = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic                     load;
    logic                     remove;
    logic                     grant;
    logic [SLOT_W-1:0]        slot;
    logic signed [PRIO_W-1:0] prio;
    logic [TIME_W-1:0]        period;
    logic [TIME_W-1:0]        offset;
    logic [TIME_W-1:0]        now;
    logic signed [PRIO_W-1:0] floor_prio;
  } cmd_t;

  // Best pending slot so far, handed along the chain.
  typedef struct packed {
    logic                     found;
    logic signed [PRIO_W-1:0] prio;
    logic signed [TIME_W-1:0] wait_time;
    logic [SLOT_W-1:0]        slot;
  } cand_t;

endpackage

@@ rtl/pts_req_if.sv @@
// Request channel: action, time, floor and load fields.
interface pts_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [31:0]       now_time;
  logic signed [7:0] running_floor;
  logic [2:0]        slot;
  logic signed [7:0] load_priority;
  logic [31:0]       load_period;
  logic [31:0]       load_offset;

  modport source (output valid, action, now_time, running_floor, slot, load_priority,
                  load_period, load_offset, input ready);
  modport sink   (input valid, action, now_time, running_floor, slot, load_priority,
                  load_period, load_offset, output ready);
endinterface

@@ rtl/pts_rsp_if.sv @@
// Response channel: grant flag and granted slot.
interface pts_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic [2:0] granted_slot;

  modport source (output valid, granted, granted_slot, input ready);
  modport sink   (input valid, granted, granted_slot, output ready);
endinterface

@@ rtl/pts_cell.sv @@
// One task slot: holds its state, visits itself when the scan token arrives.
module pts_cell
  import pts_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  logic  token_in,
  input  cand_t cand_in,
  output logic  token_out,
  output cand_t cand_out
);

  logic                     used;
  logic                     started;
  logic signed [PRIO_W-1:0] prio;
  logic [TIME_W-1:0]        period;
  logic [TIME_W-1:0]        offset;
  logic [TIME_W-1:0]        next_run;

  logic                     hit;
  logic                     visit;
  logic [TIME_W-1:0]        next_base;
  logic signed [TIME_W-1:0] wait_time;
  logic                     wrap;
  logic                     pending;
  logic                     better;

  assign hit   = (cmd.slot == SLOT_W'(INDEX));
  assign visit = token_in && used && (prio > cmd.floor_prio);

  always_comb begin
    next_base = started ? next_run : cmd.now + offset;
    wait_time = started ? $signed(next_run - cmd.now) : $signed(offset);
    wrap      = wait_time < WRAP_LIMIT_NEG;
    pending   = wait_time <= 0;
    // earlier slots already hold the candidate, so only a strictly better one takes over
    better    = !cand_in.found || (prio > cand_in.prio) ||
                ((prio == cand_in.prio) && (wait_time < cand_in.wait_time));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= 1'b0;
      started   <= 1'b0;
      token_out <= 1'b0;
    end else begin
      token_out <= token_in;
      if (cmd.load && hit) begin
        used    <= 1'b1;
        started <= 1'b0;
      end else if (cmd.remove && hit) begin
        used    <= 1'b0;
        started <= 1'b0;
      end else if (visit) begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && hit) begin
      prio   <= cmd.prio;
      period <= cmd.period;
      offset <= cmd.offset;
    end
    if (visit) begin
      next_run <= wrap ? next_base + WRAP_STEP : next_base;
    end else if (cmd.grant && hit) begin
      next_run <= next_run + period;
    end
    if (visit && pending && better) begin
      cand_out.found     <= 1'b1;
      cand_out.prio      <= prio;
      cand_out.wait_time <= wait_time;
      cand_out.slot      <= SLOT_W'(INDEX);
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

@@ rtl/periodic_task_scheduler.sv @@
// Periodic task scheduler top level: request handling, scan chain and response register.
//
// Each slot lives in its own cell, and the cells form a chain. Load and remove
// beats act in the cycle they are accepted. A select beat sends a token down
// the chain, one cell per cycle; each used cell above the floor that it reaches
// updates its start and wrap state, and each cell hands the best pending
// candidate so far to the next cell. The result at the end of the chain goes
// into a result register and then into the response register; load and remove
// go straight to the finish state. The next request is taken once the previous result
// has moved into the response register, which holds it until the sink takes it.
module periodic_task_scheduler
  import pts_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8
) (
  input logic   clk,
  input logic   rst,
  pts_req_if.sink   req,
  pts_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [TIME_W-1:0]        scan_now;
  logic signed [PRIO_W-1:0] scan_floor;
  logic                     res_granted;
  logic [OUT_SLOT_W-1:0]    res_slot;
  logic                     out_valid;
  logic                     out_granted;
  logic [OUT_SLOT_W-1:0]    out_slot;

  logic [SLOT_COUNT:0]      token;
  cand_t                    cand [SLOT_COUNT+1];
  cmd_t                     cmd;
  logic                     accept;
  logic                     done;
  logic                     out_free;

  assign req.ready        = (state == ST_IDLE);
  assign accept           = req.valid && req.ready;
  assign done             = token[SLOT_COUNT];
  assign out_free         = !out_valid || rsp.ready;
  assign rsp.valid        = out_valid;
  assign rsp.granted      = out_granted;
  assign rsp.granted_slot = out_slot;

  assign cand[0] = '0;

  always_comb begin
    cmd            = '0;
    cmd.load       = accept && (req.action == ACT_LOAD);
    cmd.remove     = accept && (req.action == ACT_REMOVE);
    cmd.grant      = done && cand[SLOT_COUNT].found;
    cmd.slot       = cmd.grant ? cand[SLOT_COUNT].slot : SLOT_W'(req.slot);
    cmd.prio       = req.load_priority;
    cmd.period     = req.load_period;
    cmd.offset     = req.load_offset;
    cmd.now        = scan_now;
    cmd.floor_prio = scan_floor;
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    pts_cell #(.INDEX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .token_in  (token[i]),
      .cand_in   (cand[i]),
      .token_out (token[i+1]),
      .cand_out  (cand[i+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.action == ACT_SELECT) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      token[0]  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      token[0] <= accept && (req.action == ACT_SELECT);
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_now    <= req.now_time;
      scan_floor  <= req.running_floor;
      res_granted <= 1'b0;
      res_slot    <= '0;
    end else if (done) begin
      res_granted <= cand[SLOT_COUNT].found;
      res_slot    <= cand[SLOT_COUNT].found ? cand[SLOT_COUNT].slot[OUT_SLOT_W-1:0] : '0;
    end
    if ((state == ST_FINISH) && out_free) begin
      out_granted <= res_granted;
      out_slot    <= res_slot;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(token))
    else $error("more than one scan token in the chain");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    (|token) |-> (state == ST_SCAN))
    else $error("scan token outside a scan");

  a_no_grant_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_granted) |-> (out_slot == '0))
    else $error("slot reported without a grant");

  a_update_finish: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.action != ACT_SELECT)) |=> (state == ST_FINISH))
    else $error("load or remove did not go straight to finish");

  a_grant_once: assert property (@(posedge clk) disable iff (rst)
    cmd.grant |=> !cmd.grant)
    else $error("grant applied twice");

endmodule

@@ dv/tb.sv @@
// Testbench for the periodic task scheduler: directed and random beats checked against a grant predictor.
`timescale 1ns / 1ps

module tb
  import pts_pkg::*;
();

  localparam int SLOTS        = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_TICKS = 20;
  localparam int MAX_REPORTS  = 40;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [1:0]        act;
    logic [31:0]       now_time;
    logic signed [7:0] floor_prio;
    logic [2:0]        slot;
    logic signed [7:0] prio;
    logic [31:0]       period;
    logic [31:0]       offset;
  } sched_req_t;

  typedef struct {
    logic       granted;
    logic [2:0] slot;
  } grant_t;

  logic clk;
  logic rst;

  pts_req_if req();
  pts_rsp_if rsp();

  periodic_task_scheduler #(.SLOT_COUNT(SLOTS)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow of the task table
  logic              tbl_used    [SLOTS];
  logic              tbl_started [SLOTS];
  logic signed [7:0] tbl_prio    [SLOTS];
  logic [31:0]       tbl_period  [SLOTS];
  logic [31:0]       tbl_offset  [SLOTS];
  logic [31:0]       tbl_due     [SLOTS];

  grant_t      grant_q[$];
  grant_t      want;
  int unsigned errors;
  int unsigned idle_cycles;
  bit          req_idle_en;
  bit          rsp_idle_en;
  logic [31:0] sim_now;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic grant_t predict_grant(input sched_req_t r);
    grant_t            res;
    logic signed [31:0] lag;
    logic signed [31:0] best_lag;
    logic signed [7:0]  best_prio;
    int                 i;
    res.granted = 1'b0;
    res.slot    = '0;
    best_lag    = '0;
    best_prio   = '0;
    if (r.act == ACT_LOAD) begin
      if (r.slot < SLOTS) begin
        tbl_used[r.slot]    = 1'b1;
        tbl_started[r.slot] = 1'b0;
        tbl_prio[r.slot]    = r.prio;
        tbl_period[r.slot]  = r.period;
        tbl_offset[r.slot]  = r.offset;
      end
    end else if (r.act == ACT_REMOVE) begin
      if (r.slot < SLOTS) begin
        tbl_used[r.slot]    = 1'b0;
        tbl_started[r.slot] = 1'b0;
      end
    end else if (r.act == ACT_SELECT) begin
      for (i = 0; i < SLOTS; i++) begin
        if (tbl_used[i] && tbl_prio[i] > r.floor_prio) begin
          if (!tbl_started[i]) begin
            tbl_due[i]     = r.now_time + tbl_offset[i];
            tbl_started[i] = 1'b1;
          end
          lag = tbl_due[i] - r.now_time;
          // the nudge leaves this decision's lag alone
          if (lag < WRAP_LIMIT_NEG) tbl_due[i] = tbl_due[i] + WRAP_STEP;
          if (lag <= 0) begin
            if (!res.granted || tbl_prio[i] > best_prio ||
                (tbl_prio[i] == best_prio && lag < best_lag)) begin
              res.granted = 1'b1;
              res.slot    = i[2:0];
              best_prio   = tbl_prio[i];
              best_lag    = lag;
            end
          end
        end
      end
      if (res.granted) tbl_due[res.slot] = tbl_due[res.slot] + tbl_period[res.slot];
    end
    return res;
  endfunction

  function automatic sched_req_t make_load(input logic [2:0] s, input logic signed [7:0] p,
                                           input logic [31:0] per, input logic [31:0] off);
    sched_req_t r;
    r.act        = ACT_LOAD;
    r.now_time   = $urandom;
    r.floor_prio = 8'($urandom);
    r.slot       = s;
    r.prio       = p;
    r.period     = per;
    r.offset     = off;
    return r;
  endfunction

  function automatic sched_req_t make_remove(input logic [2:0] s);
    sched_req_t r;
    r      = make_load(s, 8'($urandom), $urandom, $urandom);
    r.act  = ACT_REMOVE;
    return r;
  endfunction

  function automatic sched_req_t make_select(input logic [31:0] now,
                                             input logic signed [7:0] fl);
    sched_req_t r;
    r            = make_load(3'($urandom), 8'($urandom), $urandom, $urandom);
    r.act        = ACT_SELECT;
    r.now_time   = now;
    r.floor_prio = fl;
    return r;
  endfunction

  function automatic logic signed [7:0] rand_prio();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 40) - 20);
  endfunction

  function automatic logic signed [7:0] rand_floor();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return -8'sd128;
    if (pick < 9) return 8'($urandom_range(0, 40) - 20);
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] rand_span();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 300);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
  endtask

  // Drive one request beat, with an occasional random hold-off in front of it when req_idle_en is set.
  task automatic send_item(input sched_req_t r);
    grant_t g;
    if (req_idle_en && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    @(negedge clk);
    req.valid         = 1'b1;
    req.action        = r.act;
    req.now_time      = r.now_time;
    req.running_floor = r.floor_prio;
    req.slot          = r.slot;
    req.load_priority = r.prio;
    req.load_period   = r.period;
    req.load_offset   = r.offset;
    do @(posedge clk); while (!req.ready);
    g       = predict_grant(r);
    grant_q = {grant_q, g};
  endtask

  task automatic drain_grants();
    @(negedge clk);
    req.valid = 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_grant();
    send_item(make_load(3'd0, 8'sd127, 32'd0, 32'd0));
    send_item(make_load(3'd7, -8'sd128, 32'hFFFF_FFFF, 32'd0));
    send_item(make_select(32'd0, -8'sd128));
    send_item(make_select(32'd0, 8'sd127));
    send_item(make_select(32'd0, 8'sd126));
    send_item(make_remove(3'd0));
  endtask

  // Equal priorities with equal lag split on slot; higher priority wins at equal lag.
  task automatic test_priority_ties();
    send_item(make_load(3'd2, 8'sd5, 32'd100, 32'd0));
    send_item(make_load(3'd3, 8'sd5, 32'd100, 32'd0));
    send_item(make_load(3'd4, 8'sd5, 32'd100, 32'd0));
    send_item(make_load(3'd1, 8'sd4, 32'd100, 32'd0));
    send_item(make_select(32'd1000, -8'sd128));
    send_item(make_select(32'd1000, -8'sd128));
    send_item(make_select(32'd1050, -8'sd128));
    send_item(make_select(32'd1050, -8'sd128));
  endtask

  task automatic test_wrap_extremes();
    send_item(make_load(3'd5, 8'sd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_select(32'hFFFF_FFFF, 8'sd9));
    // far overdue: lag below -2^30 pulls the due time forward
    send_item(make_select(32'h7000_0000, 8'sd9));
  endtask

  task automatic test_odd_requests();
    sched_req_t r;
    send_item(make_remove(3'd6));
    send_item(make_load(3'd5, 8'sd10, 32'd10, 32'h7FFF_FFFF));
    r     = make_select($urandom, 8'($urandom));
    r.act = ACT_SPARE;
    send_item(r);
    send_item(make_select(32'd0, 8'sd9));
    send_item(make_select(32'h7FFF_FFFF, 8'sd9));
  endtask

  task automatic test_random_traffic(input int n);
    sched_req_t  r;
    int          done;
    int unsigned pick;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        r = make_load(3'($urandom), rand_prio(), rand_span(), rand_span());
      end else if (pick < 12) begin
        r = make_remove(3'($urandom));
      end else if (pick < 14) begin
        r     = make_select($urandom, 8'($urandom));
        r.act = ACT_SPARE;
      end else if (pick < 17) begin
        r = make_select($urandom, 8'($urandom));
      end else begin
        if ($urandom_range(0, 49) == 0) sim_now = $urandom;
        else sim_now = sim_now + $urandom_range(0, 60);
        r = make_select(sim_now, rand_floor());
      end
      send_item(r);
      if (r.act != ACT_SPARE) done++;
    end
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (grant_q.size() == 0) begin
        report_mismatch("grant beat with no request outstanding");
      end else begin
        want = grant_q.pop_front();
        if (rsp.granted !== want.granted)
          report_mismatch($sformatf("granted %b, want %b", rsp.granted, want.granted));
        if (rsp.granted_slot !== want.slot)
          report_mismatch($sformatf("granted_slot %0d, want %0d", rsp.granted_slot, want.slot));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t timeout, %0d grants outstanding", $time, grant_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    errors            = 0;
    idle_cycles       = 0;
    sim_now           = '0;
    req_idle_en       = 1'b1;
    rsp_idle_en       = 1'b1;
    req.valid         = 1'b0;
    req.action        = ACT_SELECT;
    req.now_time      = '0;
    req.running_floor = '0;
    req.slot          = '0;
    req.load_priority = '0;
    req.load_period   = '0;
    req.load_offset   = '0;
    foreach (tbl_used[i]) begin
      tbl_used[i]    = 1'b0;
      tbl_started[i] = 1'b0;
    end
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_grant();
    test_priority_ties();
    test_wrap_extremes();
    test_odd_requests();
    drain_grants();

    test_random_traffic(700);
    drain_grants();
    test_random_traffic(500);
    // closing stretch at full rate
    req_idle_en = 1'b0;
    rsp_idle_en = 1'b0;
    test_random_traffic(300);
    drain_grants();
    repeat (SETTLE_TICKS) @(posedge clk);

    if (errors == 0 && grant_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
